// File: hw/rtl/gmcp_pkg.sv
package gmcp_pkg;

    localparam int H_W    = 4;
    localparam int COST_W = 14;
    localparam int SIDE_W = 6;

    localparam logic [COST_W-1:0] COST_NONE = '1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CLEAR,
        S_SCAN,
        S_SETTLE,
        S_NB_RD,
        S_NB_WR,
        S_RES_RD,
        S_RES_WR
    } t_state;

    typedef enum logic [1:0] {
        DIR_UP,
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT
    } t_dir;

endpackage

// File: hw/rtl/gmcp_ram.sv
module gmcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/grid_min_climb_path.sv
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+------------------------
// in       | input     | i_in_valid / o_in_ready    | i_height
// out      | output    | o_out_valid / i_out_ready  | o_min_cost
// cfg      | input     | i_cfg_we (no wait)         | i_cfg_data (grid side)
//
// Loading accepts one cell per cycle; the last cell of an n-cell grid starts the search.
// Search: clear the cost memory, then n+1 rounds, each a full scan of the cost memory
// (one read port) plus settling and relaxing the neighbors of the cell it found, then
// the result states S_RES_RD and S_RES_WR. No input meanwhile.
// Reset is synchronous, active low, and restores a side of 32 (or MAX_SIDE if less).
// A finished result waits in the output register while the next grid loads; a second
// result held back by it stalls the search and the input until the output drains.
module grid_min_climb_path #(
    parameter int MAX_SIDE = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gmcp_pkg::SIDE_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [gmcp_pkg::H_W-1:0]        i_height,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [gmcp_pkg::COST_W-1:0]     o_min_cost
);
    import gmcp_pkg::*;

    localparam int CELLS  = MAX_SIDE * MAX_SIDE;
    localparam int CELL_W = $clog2(CELLS);
    localparam int RST_SIDE_I = (32 > MAX_SIDE) ? MAX_SIDE : 32;
    localparam logic [SIDE_W-1:0] RST_SIDE = SIDE_W'(RST_SIDE_I);

    function automatic logic [SIDE_W-1:0] f_eff_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] s;
        s = v;
        if (v == '0) begin
            s = SIDE_W'(1);
        end else if ({1'b0, v} > (SIDE_W+1)'(MAX_SIDE)) begin
            s = SIDE_W'(MAX_SIDE);
        end
        return s;
    endfunction

    function automatic logic [CELL_W-1:0] f_last(input logic [SIDE_W-1:0] s);
        logic [2*SIDE_W-1:0] p;
        p = s * s;
        return CELL_W'(p - 1'b1);
    endfunction

    // control registers
    t_state              r_state, n_state;
    logic [CELL_W-1:0]   r_load, n_load;
    logic [SIDE_W-1:0]   r_side, n_side;
    logic [CELL_W-1:0]   r_last, n_last;
    logic                r_issuing, n_issuing;
    logic                r_pend, n_pend;
    logic                r_out_valid, n_out_valid;

    // datapath registers
    logic [CELL_W-1:0]   r_k, n_k;
    logic [SIDE_W-1:0]   r_row, n_row;
    logic [SIDE_W-1:0]   r_col, n_col;
    logic [CELL_W-1:0]   r_pk, n_pk;
    logic [SIDE_W-1:0]   r_prow, n_prow;
    logic [SIDE_W-1:0]   r_pcol, n_pcol;
    logic [CELL_W-1:0]   r_best, n_best;
    logic [SIDE_W-1:0]   r_brow, n_brow;
    logic [SIDE_W-1:0]   r_bcol, n_bcol;
    logic [COST_W-1:0]   r_best_cost, n_best_cost;
    logic                r_found, n_found;
    t_dir                r_dir, n_dir;
    logic                r_hb_load, n_hb_load;
    logic [H_W-1:0]      r_hb, n_hb;
    logic [CELL_W-1:0]   r_nb, n_nb;
    logic [COST_W-1:0]   r_min_cost, n_min_cost;

    // memory ports
    logic                h_we, h_re;
    logic [CELL_W-1:0]   h_waddr, h_raddr;
    logic [H_W-1:0]      h_wdata, h_rdata;
    logic                c_we, c_re;
    logic [CELL_W-1:0]   c_waddr, c_raddr;
    logic [COST_W:0]     c_wdata, c_rdata;
    logic                c_rd_done;
    logic [COST_W-1:0]   c_rd_cost;

    // combinational helpers
    logic                in_acc;
    logic                cand;
    logic                nb_ok;
    logic [CELL_W-1:0]   nb_addr;
    t_dir                dir_next;
    logic [H_W-1:0]      diff;
    logic [COST_W:0]     sum;
    logic [SIDE_W:0]     col_inc, row_inc, bcol_inc, brow_inc;

    gmcp_ram #(.WIDTH(H_W), .DEPTH(CELLS)) u_height_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_re    (h_re),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    // entry = {done mark, cost}
    gmcp_ram #(.WIDTH(COST_W + 1), .DEPTH(CELLS)) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    assign c_rd_done = c_rdata[COST_W];
    assign c_rd_cost = c_rdata[COST_W-1:0];

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_min_cost  = r_min_cost;
    assign in_acc      = i_in_valid && o_in_ready;

    assign col_inc  = {1'b0, r_col} + 1'b1;
    assign row_inc  = {1'b0, r_row} + 1'b1;
    assign bcol_inc = {1'b0, r_bcol} + 1'b1;
    assign brow_inc = {1'b0, r_brow} + 1'b1;

    assign cand = r_pend && !c_rd_done && (c_rd_cost < r_best_cost);

    assign diff = (r_hb > h_rdata) ? (r_hb - h_rdata) : (h_rdata - r_hb);
    assign sum  = {1'b0, r_best_cost} + (COST_W+1)'(diff);

    always_comb begin
        nb_ok    = 1'b0;
        nb_addr  = r_best;
        dir_next = DIR_UP;
        case (r_dir)
            DIR_UP: begin
                nb_ok    = (r_brow != '0);
                nb_addr  = r_best - CELL_W'(r_side);
                dir_next = DIR_RIGHT;
            end
            DIR_RIGHT: begin
                nb_ok    = (bcol_inc < {1'b0, r_side});
                nb_addr  = r_best + 1'b1;
                dir_next = DIR_DOWN;
            end
            DIR_DOWN: begin
                nb_ok    = (brow_inc < {1'b0, r_side});
                nb_addr  = r_best + CELL_W'(r_side);
                dir_next = DIR_LEFT;
            end
            DIR_LEFT: begin
                nb_ok    = (r_bcol != '0);
                nb_addr  = r_best - 1'b1;
                dir_next = DIR_UP;
            end
            default: begin
                nb_ok    = 1'b0;
                nb_addr  = r_best;
                dir_next = DIR_UP;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_load      = r_load;
        n_side      = r_side;
        n_last      = r_last;
        n_issuing   = r_issuing;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_k         = r_k;
        n_row       = r_row;
        n_col       = r_col;
        n_pk        = r_pk;
        n_prow      = r_prow;
        n_pcol      = r_pcol;
        n_best      = r_best;
        n_brow      = r_brow;
        n_bcol      = r_bcol;
        n_best_cost = r_best_cost;
        n_found     = r_found;
        n_dir       = r_dir;
        n_hb_load   = r_hb_load;
        n_hb        = r_hb;
        n_nb        = r_nb;
        n_min_cost  = r_min_cost;

        h_we    = 1'b0;
        h_waddr = r_load;
        h_wdata = i_height;
        h_re    = 1'b0;
        h_raddr = r_best;
        c_we    = 1'b0;
        c_waddr = r_k;
        c_wdata = {1'b0, COST_NONE};
        c_re    = 1'b0;
        c_raddr = r_k;

        // drop the result once the output transaction completes
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            n_side = f_eff_side(i_cfg_data);
            n_last = f_last(f_eff_side(i_cfg_data));
            n_load = '0;
        end

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    h_we = 1'b1;
                    if (r_load == r_last) begin
                        n_load  = '0;
                        n_k     = '0;
                        n_state = S_CLEAR;
                    end else begin
                        n_load = r_load + 1'b1;
                    end
                end
            end

            S_CLEAR: begin
                c_we    = 1'b1;
                c_waddr = r_k;
                c_wdata = (r_k == '0) ? '0 : {1'b0, COST_NONE};
                if (r_k == r_last) begin
                    n_state     = S_SCAN;
                    n_k         = '0;
                    n_row       = '0;
                    n_col       = '0;
                    n_issuing   = 1'b1;
                    n_pend      = 1'b0;
                    n_best_cost = COST_NONE;
                    n_found     = 1'b0;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end

            S_SCAN: begin
                // issue one read per cycle, evaluate each in the cycle after its issue
                n_pend = r_issuing;
                if (r_issuing) begin
                    c_re    = 1'b1;
                    c_raddr = r_k;
                    n_pk    = r_k;
                    n_prow  = r_row;
                    n_pcol  = r_col;
                    if (r_k == r_last) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_k = r_k + 1'b1;
                        if (col_inc == {1'b0, r_side}) begin
                            n_col = '0;
                            n_row = r_row + 1'b1;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                end
                if (cand) begin
                    n_best      = r_pk;
                    n_brow      = r_prow;
                    n_bcol      = r_pcol;
                    n_best_cost = c_rd_cost;
                    n_found     = 1'b1;
                end
                if (r_pend && (r_pk == r_last)) begin
                    n_pend  = 1'b0;
                    n_state = (r_found || cand) ? S_SETTLE : S_RES_RD;
                end
            end

            S_SETTLE: begin
                c_we      = 1'b1;
                c_waddr   = r_best;
                c_wdata   = {1'b1, r_best_cost};
                h_re      = 1'b1;
                h_raddr   = r_best;
                n_dir     = DIR_UP;
                n_hb_load = 1'b1;
                n_state   = S_NB_RD;
            end

            S_NB_RD: begin
                if (r_hb_load) begin
                    n_hb      = h_rdata;
                    n_hb_load = 1'b0;
                end
                if (nb_ok) begin
                    c_re    = 1'b1;
                    c_raddr = nb_addr;
                    h_re    = 1'b1;
                    h_raddr = nb_addr;
                    n_nb    = nb_addr;
                    n_state = S_NB_WR;
                end else if (r_dir == DIR_LEFT) begin
                    n_state     = S_SCAN;
                    n_k         = '0;
                    n_row       = '0;
                    n_col       = '0;
                    n_issuing   = 1'b1;
                    n_pend      = 1'b0;
                    n_best_cost = COST_NONE;
                    n_found     = 1'b0;
                end else begin
                    n_dir = dir_next;
                end
            end

            S_NB_WR: begin
                if (!c_rd_done && (sum < {1'b0, c_rd_cost})) begin
                    c_we    = 1'b1;
                    c_waddr = r_nb;
                    c_wdata = {1'b0, sum[COST_W-1:0]};
                end
                if (r_dir == DIR_LEFT) begin
                    n_state     = S_SCAN;
                    n_k         = '0;
                    n_row       = '0;
                    n_col       = '0;
                    n_issuing   = 1'b1;
                    n_pend      = 1'b0;
                    n_best_cost = COST_NONE;
                    n_found     = 1'b0;
                end else begin
                    n_dir   = dir_next;
                    n_state = S_NB_RD;
                end
            end

            S_RES_RD: begin
                c_re    = 1'b1;
                c_raddr = r_last;
                n_state = S_RES_WR;
            end

            S_RES_WR: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_min_cost  = c_rd_cost;
                    n_state     = S_LOAD;
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_load      <= '0;
            r_side      <= RST_SIDE;
            r_last      <= f_last(RST_SIDE);
            r_issuing   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load      <= n_load;
            r_side      <= n_side;
            r_last      <= n_last;
            r_issuing   <= n_issuing;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_row       <= n_row;
        r_col       <= n_col;
        r_pk        <= n_pk;
        r_prow      <= n_prow;
        r_pcol      <= n_pcol;
        r_best      <= n_best;
        r_brow      <= n_brow;
        r_bcol      <= n_bcol;
        r_best_cost <= n_best_cost;
        r_found     <= n_found;
        r_dir       <= n_dir;
        r_hb_load   <= n_hb_load;
        r_hb        <= n_hb;
        r_nb        <= n_nb;
        r_min_cost  <= n_min_cost;
    end

`ifndef SYNTH
    a_result_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RES_WR))
        else $error("result raised outside the result state");

    a_no_cost_write_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !c_we)
        else $error("cost memory written while loading");

    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load <= r_last)
        else $error("load count beyond grid size");

    a_best_never_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && $past(r_state == S_SCAN) |-> r_best_cost <= $past(r_best_cost))
        else $error("scan minimum increased");
`endif

endmodule
